// File: rtl/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg - shared types and constants for the repeat timer table
// Slot count, counter width, payload field types and the structs that travel
// between neighboring timer cells.
// ----------------------------------------------------------------------------
`default_nettype none

package mst_pkg;

    localparam int SLOTS      = 4;
    localparam int COUNT_BITS = 8;
    localparam int MASK_W     = 4;
    localparam int SLOT_W     = 2;
    localparam int FIELD_W    = 8;

    typedef enum logic
    {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } cmd_t;

    typedef logic [SLOT_W-1:0]     slot_idx_t;
    typedef logic [FIELD_W-1:0]    field_t;
    typedef logic [COUNT_BITS-1:0] cnt_t;
    typedef logic [MASK_W-1:0]     mask_t;

    // Load select rippling down the row: each cell takes it when idx is zero.
    typedef struct packed
    {
        logic      valid;
        slot_idx_t idx;
    } sel_t;

    // Masks collected from the far end of the row toward cell 0.
    typedef struct packed
    {
        mask_t fired;
        mask_t active;
    } masks_t;

endpackage : mst_pkg

`default_nettype wire

// File: rtl/mst_in_if.sv
// ----------------------------------------------------------------------------
// mst_in_if - request channel of the repeat timer table
// Valid/ready channel carrying tick and load requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface mst_in_if;

    logic               valid;
    logic               ready;
    mst_pkg::cmd_t      cmd;
    mst_pkg::slot_idx_t slot;
    mst_pkg::field_t    period;
    mst_pkg::field_t    repeat_count;

    modport source (output valid, output cmd, output slot, output period,
                    output repeat_count, input ready);
    modport sink   (input valid, input cmd, input slot, input period,
                    input repeat_count, output ready);

endinterface : mst_in_if

`default_nettype wire

// File: rtl/mst_out_if.sv
// ----------------------------------------------------------------------------
// mst_out_if - result channel of the repeat timer table
// Valid/ready channel carrying the fired and active slot masks.
// ----------------------------------------------------------------------------
`default_nettype none

interface mst_out_if;

    logic           valid;
    logic           ready;
    mst_pkg::mask_t fired_mask;
    mst_pkg::mask_t active_mask;

    modport source (output valid, output fired_mask, output active_mask,
                    input ready);
    modport sink   (input valid, input fired_mask, input active_mask,
                    output ready);

endinterface : mst_out_if

`default_nettype wire

// File: rtl/multi_slot_repeat_timer.sv
// ----------------------------------------------------------------------------
// multi_slot_repeat_timer - table of repeating timer slots
// A row of slot cells advanced by tick requests and armed by load requests;
// every request returns the fired and active masks.
//
//   channel | dir | payload
//   --------+-----+-------------------------------------------
//   req     | in  | cmd, slot, period, repeat_count
//   rsp     | out | fired_mask, active_mask
//
// One request per cycle unless the response stalls; the response appears in
// the output register in the cycle after acceptance. The cycle time is set
// by the select and mask ripple through the row of SLOTS cells. Reset clears
// every slot and empties the output register. A stalled response holds and
// blocks a new request only while it is not taken in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_slot_repeat_timer
(
    input  wire logic clk,
    input  wire logic rst_n,
    mst_in_if.sink    req,
    mst_out_if.source rsp
);

    import mst_pkg::*;

    logic   step;
    sel_t   sel_chain   [SLOTS+1];
    masks_t masks_chain [SLOTS+1];

    logic  out_valid_reg;
    mask_t out_fired_reg;
    mask_t out_active_reg;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign step      = req.valid && req.ready;

    assign sel_chain[0].valid  = (req.cmd == CMD_LOAD);
    assign sel_chain[0].idx    = req.slot;
    assign masks_chain[SLOTS]  = '0;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        mst_cell u_cell
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .step         (step),
            .cmd          (req.cmd),
            .period       (req.period),
            .repeat_count (req.repeat_count),
            .sel_in       (sel_chain[i]),
            .sel_out      (sel_chain[i+1]),
            .masks_in     (masks_chain[i+1]),
            .masks_out    (masks_chain[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            out_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_fired_reg  <= masks_chain[0].fired;
            out_active_reg <= masks_chain[0].active;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.fired_mask  = out_fired_reg;
    assign rsp.active_mask = out_active_reg;

endmodule : multi_slot_repeat_timer

`default_nettype wire

// File: rtl/mst_cell.sv
// ----------------------------------------------------------------------------
// mst_cell - one timer slot
// Holds period, repeat count, elapsed count and the armed flag of one slot.
// Passes the load select on to the next cell and shifts its own fired and
// active bits into the masks coming back from the far end of the row.
// ----------------------------------------------------------------------------
`default_nettype none

module mst_cell
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire mst_pkg::cmd_t   cmd,
    input  wire mst_pkg::field_t period,
    input  wire mst_pkg::field_t repeat_count,
    input  wire mst_pkg::sel_t   sel_in,
    output mst_pkg::sel_t        sel_out,
    input  wire mst_pkg::masks_t masks_in,
    output mst_pkg::masks_t      masks_out
);

    import mst_pkg::*;

    cnt_t period_reg,  period_next;
    cnt_t remain_reg,  remain_next;
    cnt_t elapsed_reg, elapsed_next;
    logic active_reg,  active_next;

    logic hit;
    logic fire;
    cnt_t elapsed_inc;

    always_comb
    begin
        hit         = sel_in.valid && (sel_in.idx == '0);
        sel_out.valid = sel_in.valid && (sel_in.idx != '0);
        sel_out.idx   = sel_in.idx - SLOT_W'(1);

        // elapsed counter saturates at its top value
        elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + COUNT_BITS'(1) : elapsed_reg;
        fire        = (cmd == CMD_TICK) && active_reg && (elapsed_inc >= period_reg);

        period_next  = period_reg;
        remain_next  = remain_reg;
        elapsed_next = elapsed_reg;
        active_next  = active_reg;

        if (cmd == CMD_LOAD)
        begin
            if (hit)
            begin
                period_next  = COUNT_BITS'(period);
                remain_next  = COUNT_BITS'(repeat_count);
                elapsed_next = '0;
                active_next  = 1'b1;
            end
        end
        else if (active_reg)
        begin
            elapsed_next = fire ? '0 : elapsed_inc;
            if (fire)
            begin
                if (remain_reg == COUNT_BITS'(1))
                begin
                    active_next = 1'b0;
                    remain_next = '0;
                end
                else if (remain_reg != '0)
                begin
                    remain_next = remain_reg - COUNT_BITS'(1);
                end
            end
        end

        masks_out.fired  = {masks_in.fired[MASK_W-2:0], fire};
        masks_out.active = {masks_in.active[MASK_W-2:0], active_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= '0;
            remain_reg  <= '0;
            elapsed_reg <= '0;
            active_reg  <= 1'b0;
        end
        else if (step)
        begin
            period_reg  <= period_next;
            remain_reg  <= remain_next;
            elapsed_reg <= elapsed_next;
            active_reg  <= active_next;
        end
    end

endmodule : mst_cell

`default_nettype wire

// File: bench/multi_slot_repeat_timer_tb.sv
// ----------------------------------------------------------------------------
// multi_slot_repeat_timer_tb - self-checking bench for the repeat timer table
// Streams tick and load requests into the table and compares every fired and
// active mask against an in-bench model of the slots. A directed pass covers
// the slot-table corner cases. A long output stall fills the block. A random
// pass follows, with random gaps on both channels and one gap-free stretch.
// ----------------------------------------------------------------------------

module multi_slot_repeat_timer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mst_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_REQS  = 1900;
    localparam int MAX_REPORTS  = 10;
    localparam int IDLE_PCT     = 14;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mst_in_if  req();
    mst_out_if rsp();

    multi_slot_repeat_timer u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Slot table as the bench expects it to be
    cnt_t   tmr_period  [SLOTS];
    cnt_t   tmr_left    [SLOTS];
    cnt_t   tmr_elapsed [SLOTS];
    logic   tmr_armed   [SLOTS];

    masks_t      pending_masks[$];
    int unsigned mismatches   = 0;
    int unsigned stall_cycles = 0;
    int unsigned rsp_hold_len = 0;
    bit          no_idle      = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one request to the slot table and returns the masks it yields.
    function automatic masks_t advance_timers(cmd_t c, slot_idx_t s, field_t p, field_t r);
        masks_t m;
        m = '0;
        if (c == CMD_LOAD)
        begin
            if (int'(s) < SLOTS)
            begin
                tmr_period[s]  = cnt_t'(p);
                tmr_left[s]    = cnt_t'(r);
                tmr_elapsed[s] = '0;
                tmr_armed[s]   = 1'b1;
            end
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (tmr_armed[i])
                begin
                    if (tmr_elapsed[i] != '1)
                        tmr_elapsed[i] = tmr_elapsed[i] + 1'b1;
                    if (tmr_elapsed[i] >= tmr_period[i])
                    begin
                        if (i < MASK_W)
                            m.fired[i] = 1'b1;
                        tmr_elapsed[i] = '0;
                        if (tmr_left[i] == cnt_t'(1))
                        begin
                            tmr_armed[i] = 1'b0;
                            tmr_left[i]  = '0;
                        end
                        else if (tmr_left[i] != '0)
                            tmr_left[i] = tmr_left[i] - 1'b1;
                    end
                end
            end
        end
        for (int i = 0; i < SLOTS && i < MASK_W; i++)
            m.active[i] = tmr_armed[i];
        return m;
    endfunction

    function automatic void flag_error(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s", $realtime, msg);
    endfunction

    // Request monitor, predictor and result checker
    always @(posedge clk)
    begin
        masks_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
                pending_masks.push_back(advance_timers(req.cmd, req.slot, req.period,
                                                       req.repeat_count));
            if (rsp.valid && rsp.ready)
            begin
                if (pending_masks.size() == 0)
                    flag_error($sformatf("result with no request pending: fired %b active %b",
                                         rsp.fired_mask, rsp.active_mask));
                else
                begin
                    want = pending_masks.pop_front();
                    if (rsp.fired_mask !== want.fired)
                        flag_error($sformatf("fired_mask: expected %b, got %b",
                                             want.fired, rsp.fired_mask));
                    if (rsp.active_mask !== want.active)
                        flag_error($sformatf("active_mask: expected %b, got %b",
                                             want.active, rsp.active_mask));
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL multi_slot_repeat_timer");
            $finish;
        end
    end

    // Result sink: random gaps, plus a long hold-off when a test asks for one
    initial
    begin
        int unsigned n;
        rsp.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_hold_len != 0)
            begin
                n = rsp_hold_len;
                rsp_hold_len = 0;
                rsp.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            rsp.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Drives one request and returns at the edge where it is taken.
    task automatic send_req(cmd_t c, slot_idx_t s, field_t p, field_t r);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.cmd          <= c;
        req.slot         <= s;
        req.period       <= p;
        req.repeat_count <= r;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic test_directed();
        send_req(CMD_TICK, '1, '1, '1);                 // empty table, junk fields
        send_req(CMD_LOAD, 2'd0, 8'd0, 8'd1);           // zero period, single shot
        send_req(CMD_TICK, 2'd0, 8'd0, 8'd0);           // fires and frees slot 0
        send_req(CMD_LOAD, 2'd1, 8'd2, 8'd2);
        send_req(CMD_LOAD, 2'd2, 8'd0, 8'd0);           // fires on every tick forever
        send_req(CMD_LOAD, 2'd3, 8'd255, 8'd255);       // widest period and count
        repeat (4)
            send_req(CMD_TICK, '0, '0, '0);
        send_req(CMD_LOAD, 2'd1, 8'd1, 8'd3);           // re-arm a freed slot
        send_req(CMD_TICK, '1, '1, '1);
        send_req(CMD_LOAD, 2'd1, 8'd3, 8'd0);           // reload while armed restarts it
        repeat (3)
            send_req(CMD_TICK, '0, '0, '0);
        send_req(CMD_LOAD, 2'd2, 8'd255, 8'd1);
        send_req(CMD_LOAD, 2'd0, 8'd1, 8'd255);
        repeat (4)
            send_req(CMD_TICK, '1, '1, '1);
        send_req(CMD_LOAD, 2'd3, 8'd0, 8'd2);
        send_req(CMD_TICK, '0, '0, '0);
        send_req(CMD_TICK, '0, '0, '0);
    endtask

    // Output held off while requests keep coming, so the block backs up.
    task automatic test_backpressure();
        rsp_hold_len = HOLD_CYCLES;
        send_req(CMD_LOAD, 2'd0, 8'd1, 8'd0);
        send_req(CMD_LOAD, 2'd1, 8'd2, 8'd3);
        for (int n = 0; n < 30; n++)
            send_req(CMD_TICK, slot_idx_t'($urandom), field_t'($urandom), field_t'($urandom));
    endtask

    task automatic test_random();
        cmd_t        c;
        slot_idx_t   s;
        field_t      p;
        field_t      r;
        int unsigned pick;
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            no_idle = (n >= 700 && n < 1000);
            s = slot_idx_t'($urandom);
            p = field_t'($urandom);
            r = field_t'($urandom);
            c = ($urandom_range(0, 99) < 22) ? CMD_LOAD : CMD_TICK;
            if (c == CMD_LOAD)
            begin
                // mostly short periods and counts so slots fire and free often
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    p = field_t'($urandom_range(0, 6));
                else if (pick < 90)
                    p = field_t'($urandom_range(7, 40));
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    r = '0;
                else if (pick < 70)
                    r = field_t'($urandom_range(1, 4));
                else if (pick < 90)
                    r = field_t'($urandom_range(5, 20));
            end
            send_req(c, s, p, r);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        req.valid        <= 1'b0;
        req.cmd          <= CMD_TICK;
        req.slot         <= '0;
        req.period       <= '0;
        req.repeat_count <= '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tmr_period[i]  = '0;
            tmr_left[i]    = '0;
            tmr_elapsed[i] = '0;
            tmr_armed[i]   = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random();
        req.valid <= 1'b0;

        do
            @(posedge clk);
        while (pending_masks.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_masks.size() == 0)
            $display("PASS multi_slot_repeat_timer");
        else
            $display("FAIL multi_slot_repeat_timer");
        $finish;
    end

endmodule : multi_slot_repeat_timer_tb
